FILE: hw/rtl/lct_pkg.sv
// Shared types and constants for the lease claim table.
// Holds the transaction structs, operation codes and default sizes.
// No dependencies.
package lct_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int TARGET_BITS_DEF   = 16;

  localparam logic [31:0] GRACE_MS_RESET = 32'd1000;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_CLAIM   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_QUERY   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  operator_id;
    logic [3:0]  action_kind;
    logic [15:0] target_id;
    logic [31:0] now_ms;
  } lct_in_t;

  typedef struct packed {
    logic        granted;
    logic        conflict;
    logic [7:0]  winner_id;
    logic [7:0]  loser_id;
    logic [7:0]  holder_id;
    logic        table_full;
  } lct_out_t;

endpackage

FILE: hw/rtl/lct_ram.sv
// Simple dual-port entry memory with one write and one registered read port.
// Used by lease_claim_table to hold kind, target, holder and acquire time.
// No package dependencies.
module lct_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 60,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/lease_claim_table.sv
// Lease claim table: exclusive claims keyed by action kind and target id.
// Depends on lct_pkg (types, codes, defaults) and lct_ram (entry store).
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one operation per
//   transaction: claim, release or query. Result channel (out_valid/out_ready/
//   out_data) returns exactly one result transaction per input transaction,
//   in order. cfg_we/cfg_wdata load the grace window; write it only while the
//   block is idle.
// Timing:
//   The block handles one transaction at a time. After acceptance it scans
//   the entry memory one address per cycle through the registered read
//   port, stopping at the first matching entry; a miss sweeps every entry.
// Reset:
//   rst_n low clears all valid bits, the sequencer and the result valid flag
//   and loads the grace window with 1000 ms. The entry memory itself is not
//   cleared; no entry is read as live until its valid bit is set.
// Stall:
//   The result register holds its transaction until out_ready. A new input
//   transaction is taken meanwhile; its write-back and result wait until the
//   result register is free.
module lease_claim_table #(
  parameter int TABLE_ENTRIES = lct_pkg::TABLE_ENTRIES_DEF,
  parameter int TARGET_BITS   = lct_pkg::TARGET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lct_pkg::lct_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lct_pkg::lct_out_t out_data,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  // Entry word: {kind, target, holder, acquired}
  localparam int ENT_W = 4 + TARGET_BITS + 8 + 32;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  lct_pkg::lct_in_t  item_r, item_nxt;
  lct_pkg::lct_out_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       grace_r;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [7:0]       hit_holder_r, hit_holder_nxt;
  logic [31:0]      hit_acq_r, hit_acq_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  // Memory ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;

  logic [3:0]             rd_kind;
  logic [TARGET_BITS-1:0] rd_target;
  logic [7:0]             rd_holder;
  logic [31:0]            rd_acq;
  logic [TARGET_BITS-1:0] key_target;
  logic                   hit;
  logic [31:0]            age;
  logic                   in_window;

  lct_ram #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(ENT_W),
    .AW   (IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_cnt_r[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign rd_kind    = rd_data[ENT_W-1 -: 4];
  assign rd_target  = rd_data[ENT_W-5 -: TARGET_BITS];
  assign rd_holder  = rd_data[39:32];
  assign rd_acq     = rd_data[31:0];

  // Only the low TARGET_BITS of the target take part in the key.
  assign key_target = TARGET_BITS'(item_r.target_id);

  assign hit = cmp_vld_r && valid_r[cmp_idx_r] &&
               (rd_kind == item_r.action_kind) && (rd_target == key_target);

  // Wrapping age, compared unsigned; a zero window never protects the holder.
  assign age       = item_r.now_ms - hit_acq_r;
  assign in_window = age < grace_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    valid_nxt      = valid_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_holder_nxt = hit_holder_r;
    hit_acq_nxt    = hit_acq_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    wr_en          = 1'b0;
    wr_addr        = hit_idx_r;
    wr_data        = {item_r.action_kind, key_target, item_r.operator_id, item_r.now_ms};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          rd_cnt_nxt     = '0;
          cmp_vld_nxt    = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next read while comparing the previous one.
        if (rd_cnt_r < CNT_W'(TABLE_ENTRIES)) begin
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end

        if (hit) begin
          found_nxt      = 1'b1;
          hit_idx_nxt    = cmp_idx_r;
          hit_holder_nxt = rd_holder;
          hit_acq_nxt    = rd_acq;
          cmp_vld_nxt    = 1'b0;
          state_nxt      = ST_DECIDE;
        end else if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
          // Remember the lowest free slot for a possible insert.
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end

        if (!cmp_vld_r && (rd_cnt_r == CNT_W'(TABLE_ENTRIES))) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_ready) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          case (item_r.func)
            lct_pkg::FUNC_CLAIM: begin
              if (!found_r) begin
                if (free_found_r) begin
                  wr_en              = 1'b1;
                  wr_addr            = free_idx_r;
                  valid_nxt[free_idx_r] = 1'b1;
                  out_nxt.granted    = 1'b1;
                end else begin
                  out_nxt.table_full = 1'b1;
                end
              end else if (hit_holder_r == item_r.operator_id || !in_window) begin
                // Refresh by the holder, or takeover after the window.
                wr_en           = 1'b1;
                out_nxt.granted = 1'b1;
              end else begin
                out_nxt.conflict  = 1'b1;
                out_nxt.winner_id = hit_holder_r;
                out_nxt.loser_id  = item_r.operator_id;
              end
            end
            lct_pkg::FUNC_RELEASE: begin
              if (found_r && hit_holder_r == item_r.operator_id) begin
                valid_nxt[hit_idx_r] = 1'b0;
              end
            end
            lct_pkg::FUNC_QUERY: begin
              if (found_r) begin
                out_nxt.holder_id = hit_holder_r;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      valid_r      <= '0;
      grace_r      <= lct_pkg::GRACE_MS_RESET;
      rd_cnt_r     <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      valid_r      <= valid_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      if (cfg_we) begin
        grace_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    out_r        <= out_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_holder_r <= hit_holder_nxt;
    hit_acq_r    <= hit_acq_nxt;
    free_idx_r   <= free_idx_nxt;
  end

endmodule

FILE: hw/rtl/lct_checker.sv
// Port-level assertions for lease_claim_table, attached by bind.
// Depends on lct_pkg for the transaction structs.
module lct_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lct_pkg::lct_out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during scan");

  // At most one of granted, conflict or full is set in any result.
  a_outcome_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.granted && out_data.conflict) &&
                  !(out_data.granted && out_data.table_full) &&
                  !(out_data.conflict && out_data.table_full))
    else $error("claim outcome flags overlap");

  // The holder keeping a claim is never the refused claimant.
  a_conflict_ids: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.conflict |-> out_data.winner_id != out_data.loser_id)
    else $error("conflict between equal operators");

  // Results that report a holder carry no claim flags.
  a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.holder_id != 8'd0) |->
      !out_data.granted && !out_data.conflict && !out_data.table_full)
    else $error("holder reported alongside claim flags");

endmodule

bind lease_claim_table lct_checker u_lct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
